// ===== design/cbpg_pkg.sv =====
// Shared types and constants for the cubic Bezier point generator.
// No dependencies; every other design file imports this package.
`default_nettype none

package cbpg_pkg;

    localparam int COORD_W = 16;
    localparam int Q_FRAC  = 16;
    localparam int W_W     = Q_FRAC + 1;
    localparam int N_CP    = 4;
    localparam int PROD_W  = W_W + 1 + COORD_W;
    localparam int PAIR_W  = PROD_W + 1;
    localparam int ACC_W   = PAIR_W + 1;
    localparam int RND_W   = ACC_W - Q_FRAC;

    localparam logic [W_W-1:0] Q_ONE  = W_W'(1) << Q_FRAC;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (Q_FRAC - 1);
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef enum logic [1:0] {
        KIND_MOVE  = 2'd0,
        KIND_CURVE = 2'd1,
        KIND_CLOSE = 2'd2
    } t_kind;

    typedef struct packed {
        t_coord p0_x;
        t_coord p0_y;
        t_coord p1_x;
        t_coord p1_y;
        t_coord p2_x;
        t_coord p2_y;
        t_coord p3_x;
        t_coord p3_y;
    } t_pts;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_q_ctl;

endpackage

`default_nettype wire

// ===== design/cbpg_if.sv =====
// Request channels of the Bezier point generator: control points in, points out.
// Depends on cbpg_pkg.
`default_nettype none

interface cbpg_in_if import cbpg_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord p0_x;
    t_coord p0_y;
    t_coord p1_x;
    t_coord p1_y;
    t_coord p2_x;
    t_coord p2_y;
    t_coord p3_x;
    t_coord p3_y;

    modport source (output valid, output p0_x, output p0_y, output p1_x, output p1_y,
                    output p2_x, output p2_y, output p3_x, output p3_y, input ready);
    modport sink   (input valid, input p0_x, input p0_y, input p1_x, input p1_y,
                    input p2_x, input p2_y, input p3_x, input p3_y, output ready);
endinterface

interface cbpg_out_if import cbpg_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord out_x;
    t_coord out_y;
    t_kind  point_kind;
    logic   last;

    modport source (output valid, output out_x, output out_y, output point_kind,
                    output last, input ready);
    modport sink   (input valid, input out_x, input out_y, input point_kind,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== design/cbpg_front.sv =====
// Front end: accepts control-point requests into a two-entry queue.
// Depends on cbpg_pkg and cbpg_in_if.
`default_nettype none

module cbpg_front import cbpg_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    cbpg_in_if.sink      i_in,
    output t_pts         o_head,
    input  wire t_q_ctl  i_ctl,
    output t_q_ctl       o_ctl
);

    t_pts       r_q [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt,  n_cnt;
    logic       push, pop;

    assign i_in.ready  = (r_cnt != 2'd2);
    assign push        = i_in.valid && i_in.ready;
    assign pop         = i_ctl.pop && (r_cnt != 2'd0);
    assign o_head      = r_q[r_rptr];
    assign o_ctl.valid = (r_cnt != 2'd0);
    assign o_ctl.pop   = pop;

    always_comb begin
        n_wptr = push ? ~r_wptr : r_wptr;
        n_rptr = pop  ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= '{p0_x: i_in.p0_x, p0_y: i_in.p0_y,
                             p1_x: i_in.p1_x, p1_y: i_in.p1_y,
                             p2_x: i_in.p2_x, p2_y: i_in.p2_y,
                             p3_x: i_in.p3_x, p3_y: i_in.p3_y};
        end
    end

endmodule

`default_nettype wire

// ===== design/cbpg_back.sv =====
// Back end: steps through the points of one curve and evaluates the weighted sums.
// Depends on cbpg_pkg and cbpg_out_if.
`default_nettype none

module cbpg_back import cbpg_pkg::*; #(
    parameter int SEGMENTS = 25
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_pts    i_head,
    input  wire t_q_ctl  i_ctl,
    output t_q_ctl       o_ctl,
    cbpg_out_if.source   o_out
);

    localparam int NRES   = SEGMENTS + 3;
    localparam int IDX_W  = $clog2(NRES);
    localparam int K_W    = $clog2(SEGMENTS + 1);
    localparam int KDEPTH = 2 ** K_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NRES - 1);
    localparam longint LS   = SEGMENTS;
    localparam longint CUBE = LS * LS * LS;
    localparam longint QSC  = longint'(1) << Q_FRAC;

    logic [N_CP-1:0][W_W-1:0] w_tab [KDEPTH];

    for (genvar k = 0; k < KDEPTH; k++) begin : g_w
        if (k <= SEGMENTS) begin : g_v
            localparam longint LK = k;
            localparam longint LU = LS - LK;
            localparam longint W0 = (LU * LU * LU * QSC + CUBE / 2) / CUBE;
            localparam longint W1 = (3 * LU * LU * LK * QSC + CUBE / 2) / CUBE;
            localparam longint W2 = (3 * LU * LK * LK * QSC + CUBE / 2) / CUBE;
            localparam longint W3 = (LK * LK * LK * QSC + CUBE / 2) / CUBE;
            assign w_tab[k] = {W_W'(W3), W_W'(W2), W_W'(W1), W_W'(W0)};
        end else begin : g_z
            assign w_tab[k] = '0;
        end
    end

    logic en;
    logic issue;

    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] j_m1;
    t_kind            a_kind;
    logic [N_CP-1:0][W_W-1:0] a_w;

    logic                      r_b_valid;
    t_kind                     r_b_kind;
    logic                      r_b_last;
    logic [N_CP-1:0][W_W-1:0]  r_b_w;
    t_coord                    r_b_px [N_CP];
    t_coord                    r_b_py [N_CP];

    logic                      r_c_valid;
    t_kind                     r_c_kind;
    logic                      r_c_last;
    logic signed [PROD_W-1:0]  r_c_mx [N_CP];
    logic signed [PROD_W-1:0]  r_c_my [N_CP];

    logic                      r_d_valid;
    t_kind                     r_d_kind;
    logic                      r_d_last;
    logic signed [PAIR_W-1:0]  r_d_sx [2];
    logic signed [PAIR_W-1:0]  r_d_sy [2];

    logic                      r_e_valid;
    t_kind                     r_e_kind;
    logic                      r_e_last;
    t_coord                    r_e_x;
    t_coord                    r_e_y;

    t_coord                    n_e_x, n_e_y;

    function automatic t_coord round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] b;
        logic signed [RND_W-1:0] r;
        b = acc + RND_HALF;
        r = RND_W'(b >>> Q_FRAC);
        if (r > RND_W'(COORD_MAX)) begin
            return COORD_MAX;
        end else if (r < RND_W'(COORD_MIN)) begin
            return COORD_MIN;
        end
        return COORD_W'(r);
    endfunction

    assign en          = !r_e_valid || o_out.ready;
    assign issue       = en && i_ctl.valid;
    assign o_ctl.valid = issue;
    assign o_ctl.pop   = issue && (r_j == IDX_LAST);
    assign j_m1        = r_j - IDX_W'(1);

    always_comb begin
        n_j = r_j;
        if (issue) begin
            n_j = (r_j == IDX_LAST) ? '0 : r_j + IDX_W'(1);
        end
        if (r_j == '0) begin
            a_kind = KIND_MOVE;
            a_w    = {{W_W{1'b0}}, {W_W{1'b0}}, {W_W{1'b0}}, Q_ONE};
        end else if (r_j == IDX_LAST) begin
            a_kind = KIND_CLOSE;
            a_w    = {Q_ONE, {W_W{1'b0}}, {W_W{1'b0}}, {W_W{1'b0}}};
        end else begin
            a_kind = KIND_CURVE;
            a_w    = w_tab[j_m1[K_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j       <= '0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            r_j <= n_j;
            if (en) begin
                r_b_valid <= issue;
                r_c_valid <= r_b_valid;
                r_d_valid <= r_c_valid;
                r_e_valid <= r_d_valid;
            end
        end
    end

    always_comb begin
        n_e_x = round_sat(ACC_W'(r_d_sx[0]) + ACC_W'(r_d_sx[1]));
        n_e_y = round_sat(ACC_W'(r_d_sy[0]) + ACC_W'(r_d_sy[1]));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_kind  <= a_kind;
            r_b_last  <= (r_j == IDX_LAST);
            r_b_w     <= a_w;
            r_b_px[0] <= i_head.p0_x;
            r_b_px[1] <= i_head.p1_x;
            r_b_px[2] <= i_head.p2_x;
            r_b_px[3] <= i_head.p3_x;
            r_b_py[0] <= i_head.p0_y;
            r_b_py[1] <= i_head.p1_y;
            r_b_py[2] <= i_head.p2_y;
            r_b_py[3] <= i_head.p3_y;

            r_c_kind <= r_b_kind;
            r_c_last <= r_b_last;
            for (int i = 0; i < N_CP; i++) begin
                r_c_mx[i] <= $signed({1'b0, r_b_w[i]}) * r_b_px[i];
                r_c_my[i] <= $signed({1'b0, r_b_w[i]}) * r_b_py[i];
            end

            r_d_kind  <= r_c_kind;
            r_d_last  <= r_c_last;
            r_d_sx[0] <= PAIR_W'(r_c_mx[0]) + PAIR_W'(r_c_mx[1]);
            r_d_sx[1] <= PAIR_W'(r_c_mx[2]) + PAIR_W'(r_c_mx[3]);
            r_d_sy[0] <= PAIR_W'(r_c_my[0]) + PAIR_W'(r_c_my[1]);
            r_d_sy[1] <= PAIR_W'(r_c_my[2]) + PAIR_W'(r_c_my[3]);

            r_e_kind <= r_d_kind;
            r_e_last <= r_d_last;
            r_e_x    <= n_e_x;
            r_e_y    <= n_e_y;
        end
    end

    assign o_out.valid      = r_e_valid;
    assign o_out.out_x      = r_e_x;
    assign o_out.out_y      = r_e_y;
    assign o_out.point_kind = r_e_kind;
    assign o_out.last       = r_e_last;

endmodule

`default_nettype wire

// ===== design/cubic_bezier_point_generator_unit.sv =====
// Cubic Bezier point generator, top level: request queue front end and evaluator back end.
// Depends on cbpg_pkg, cbpg_if, cbpg_front and cbpg_back.
//
// Each request of four control points yields SEGMENTS+3 output points: a move to P0,
// SEGMENTS+1 curve points at t = k/SEGMENTS (Q1.16 Bernstein weights, rounded to
// nearest and saturated), and a closing P3 flagged last. The back end issues one point
// per cycle, unless the output register is stalled, into a four-stage multiply-and-sum
// pipeline (registers B, C, D and E); it starts on the next request once the last point
// of the current one is issued. A two-entry queue takes new requests while the current
// curve is still being emitted; the output register stalls the pipeline only when the
// sink holds ready low.
`default_nettype none

module cubic_bezier_point_generator_unit import cbpg_pkg::*; #(
    parameter int SEGMENTS = 25
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cbpg_in_if.sink    i_in,
    cbpg_out_if.source o_out
);

    t_pts   head;
    t_q_ctl q_to_back;
    t_q_ctl back_to_q;

    cbpg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_head  (head),
        .i_ctl   (back_to_q),
        .o_ctl   (q_to_back)
    );

    cbpg_back #(
        .SEGMENTS (SEGMENTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_ctl   (q_to_back),
        .o_ctl   (back_to_q),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== design/cbpg_checker.sv =====
// Port-level checks on the point stream of the Bezier point generator, with its bind.
// Depends on cbpg_pkg and cubic_bezier_point_generator_unit.
`default_nettype none

module cbpg_checker import cbpg_pkg::*; (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    input wire logic  i_out_valid,
    input wire logic  i_out_ready,
    input wire t_kind i_out_kind,
    input wire logic  i_out_last
);

    logic take;
    assign take = i_out_valid && i_out_ready;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output request dropped while stalled");

    a_last_is_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_kind == KIND_CLOSE)))
        else $error("last flag and closing point disagree");

    a_move_then_curve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_out_kind == KIND_MOVE) |=> (!i_out_valid || i_out_kind == KIND_CURVE))
        else $error("move not followed by a curve point");

    a_close_then_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_out_last) |=> (!i_out_valid || i_out_kind == KIND_MOVE))
        else $error("curve end not followed by a move");

endmodule

bind cubic_bezier_point_generator_unit cbpg_checker u_cbpg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.point_kind),
    .i_out_last  (o_out.last)
);

`default_nettype wire
